FILE: hw/rtl/ldhm_pkg.sv
// Shared types and constants for the link deframer and heartbeat monitor.
// No dependencies; compiled first.
package ldhm_pkg;

    localparam int unsigned CNT_W = 24;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [7:0] TYPE_DATA      = 8'h44;
    localparam logic [7:0] TYPE_HEARTBEAT = 8'h48;

    localparam logic [CNT_W-1:0] INTERVAL_RESET = 24'd5000;
    localparam logic [CNT_W-1:0] TIMEOUT_RESET  = 24'd15000;

    localparam int unsigned PADDR_W = 3;

    // Register index taken from the word address bit
    typedef enum logic {
        REG_INTERVAL = 1'b0,
        REG_TIMEOUT  = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_BYTE       = 2'd0,
        MODE_TICK       = 2'd1,
        MODE_CONNECT    = 2'd2,
        MODE_DISCONNECT = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_TYPE    = 2'd0,
        PH_LEN     = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic {
        CAUSE_DISCONNECT = 1'b0,
        CAUSE_TIMEOUT    = 1'b1
    } cause_t;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       frame_end;
        logic       heartbeat_seen;
        logic       type_error;
        logic       send_heartbeat;
        logic       link_dropped;
        logic       drop_cause;
    } result_t;

endpackage

FILE: hw/rtl/ldhm_if.sv
// Valid/ready channel interfaces for the deframer: input items and results.
// No dependencies.
interface ldhm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] rx_byte;

    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface ldhm_out_if;
    logic       valid;
    logic       ready;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       heartbeat_seen;
    logic       type_error;
    logic       send_heartbeat;
    logic       link_dropped;
    logic       drop_cause;

    modport source (output valid, output out_valid, output out_byte, output frame_end,
                    output heartbeat_seen, output type_error, output send_heartbeat,
                    output link_dropped, output drop_cause, input ready);
    modport sink   (input valid, input out_valid, input out_byte, input frame_end,
                    input heartbeat_seen, input type_error, input send_heartbeat,
                    input link_dropped, input drop_cause, output ready);
endinterface

FILE: hw/rtl/link_deframer_heartbeat_monitor.sv
// Top level: type-length-value deframer with heartbeat supervision.
// Depends on ldhm_pkg and the channel interfaces in ldhm_if.sv.
//
//  channel   | role   | handshake    | payload
//  ----------+--------+--------------+-------------------------------------------
//  rx_item   | sink   | valid/ready  | mode, rx_byte
//  result    | source | valid/ready  | out_valid, out_byte, frame_end, ...
//  APB       | slave  | psel/penable | 24-bit interval (0x0), timeout (0x4)
//
// Each item produces exactly one result, presented in the cycle after it is accepted.
// Throughput is one item per cycle unless result stalls: the result register is
// the only stage, and a new item is taken whenever it is empty or being emptied.
// A stall on result holds the result register and back-pressures rx_item.
// Reset (rst_n, asynchronous) drops the link, clears the parser and counters
// and restores the interval to 5000 and the timeout to 15000 ticks.
// No clearing pass; the block is ready for items as soon as reset is released.
module link_deframer_heartbeat_monitor (
    input  logic                         clk,
    input  logic                         rst_n,
    ldhm_in_if.sink                      rx_item,
    ldhm_out_if.source                   result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ldhm_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import ldhm_pkg::*;

    // Configuration registers
    logic [CNT_W-1:0] interval_reg;
    logic [CNT_W-1:0] timeout_reg;

    // Parser and link state
    phase_t           phase_reg, phase_next;
    logic             is_hb_reg, is_hb_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       count_reg, count_next;
    logic             link_up_reg, link_up_next;
    logic [CNT_W-1:0] rx_cnt_reg, rx_cnt_next;
    logic [CNT_W-1:0] tx_cnt_reg, tx_cnt_next;

    // Result stage
    logic             res_valid_reg;
    result_t          res_reg, res_next;

    logic             accept;
    logic             cfg_wr;
    logic [7:0]       count_inc;
    logic [CNT_W-1:0] rx_inc;
    logic [CNT_W-1:0] tx_inc;
    mode_t            mode;
    reg_idx_t         wr_idx;

    // ---------------------------------------------------------------- APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    // Word select on address bit 2; the byte offset bits are not decoded
    assign wr_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RESET;
            timeout_reg  <= TIMEOUT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (wr_idx)
                REG_INTERVAL: interval_reg <= pwdata[CNT_W-1:0];
                REG_TIMEOUT:  timeout_reg  <= pwdata[CNT_W-1:0];
                default:      interval_reg <= interval_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (wr_idx)
            REG_INTERVAL: prdata = {{(32-CNT_W){1'b0}}, interval_reg};
            REG_TIMEOUT:  prdata = {{(32-CNT_W){1'b0}}, timeout_reg};
            default:      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------- handshake
    // Take a new item whenever the result slot is free or being drained
    assign rx_item.ready = !res_valid_reg || result.ready;
    assign accept        = rx_item.valid && rx_item.ready;
    assign mode          = mode_t'(rx_item.mode);

    // ---------------------------------------------------- next-state logic
    assign count_inc = count_reg + 8'd1;
    // Saturating tick counters
    assign rx_inc = (rx_cnt_reg == CNT_MAX) ? CNT_MAX : rx_cnt_reg + CNT_W'(1);
    assign tx_inc = (tx_cnt_reg == CNT_MAX) ? CNT_MAX : tx_cnt_reg + CNT_W'(1);

    always_comb
    begin
        phase_next   = phase_reg;
        is_hb_next   = is_hb_reg;
        len_next     = len_reg;
        count_next   = count_reg;
        link_up_next = link_up_reg;
        rx_cnt_next  = rx_cnt_reg;
        tx_cnt_next  = tx_cnt_reg;
        res_next     = '0;

        unique case (mode)
            MODE_BYTE:
            begin
                if (link_up_reg)
                begin
                    unique case (phase_reg)
                        PH_LEN:
                        begin
                            len_next   = rx_item.rx_byte;
                            count_next = 8'd0;
                            if (rx_item.rx_byte == 8'd0)
                            begin
                                // Empty frame: a heartbeat still counts
                                if (is_hb_reg)
                                begin
                                    rx_cnt_next             = '0;
                                    res_next.heartbeat_seen = 1'b1;
                                end
                                phase_next = PH_TYPE;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                        PH_PAYLOAD:
                        begin
                            count_next = count_inc;
                            if (!is_hb_reg)
                            begin
                                res_next.out_valid = 1'b1;
                                res_next.out_byte  = rx_item.rx_byte;
                            end
                            if (count_inc >= len_reg)
                            begin
                                if (is_hb_reg)
                                begin
                                    rx_cnt_next             = '0;
                                    res_next.heartbeat_seen = 1'b1;
                                end
                                else
                                begin
                                    res_next.frame_end = 1'b1;
                                end
                                phase_next = PH_TYPE;
                            end
                        end
                        default:
                        begin
                            // Waiting for type; the unused phase code lands here too
                            if (rx_item.rx_byte == TYPE_DATA ||
                                rx_item.rx_byte == TYPE_HEARTBEAT)
                            begin
                                is_hb_next = (rx_item.rx_byte == TYPE_HEARTBEAT);
                                phase_next = PH_LEN;
                            end
                            else
                            begin
                                phase_next          = PH_TYPE;
                                res_next.type_error = 1'b1;
                            end
                        end
                    endcase
                end
            end
            MODE_TICK:
            begin
                if (link_up_reg)
                begin
                    rx_cnt_next = rx_inc;
                    tx_cnt_next = tx_inc;
                    // Timeout wins over a heartbeat request on the same tick
                    if (rx_inc > timeout_reg)
                    begin
                        link_up_next          = 1'b0;
                        phase_next            = PH_TYPE;
                        is_hb_next            = 1'b0;
                        len_next              = 8'd0;
                        count_next            = 8'd0;
                        res_next.link_dropped = 1'b1;
                        res_next.drop_cause   = CAUSE_TIMEOUT;
                    end
                    else if (tx_inc >= interval_reg)
                    begin
                        tx_cnt_next             = '0;
                        res_next.send_heartbeat = 1'b1;
                    end
                end
            end
            MODE_CONNECT:
            begin
                // A second connect while up is rejected
                if (!link_up_reg)
                begin
                    link_up_next = 1'b1;
                    rx_cnt_next  = '0;
                    tx_cnt_next  = '0;
                    phase_next   = PH_TYPE;
                    is_hb_next   = 1'b0;
                    len_next     = 8'd0;
                    count_next   = 8'd0;
                end
            end
            default:
            begin
                // Disconnect
                if (link_up_reg)
                begin
                    link_up_next          = 1'b0;
                    phase_next            = PH_TYPE;
                    is_hb_next            = 1'b0;
                    len_next              = 8'd0;
                    count_next            = 8'd0;
                    res_next.link_dropped = 1'b1;
                    res_next.drop_cause   = CAUSE_DISCONNECT;
                end
            end
        endcase
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TYPE;
            is_hb_reg   <= 1'b0;
            len_reg     <= 8'd0;
            count_reg   <= 8'd0;
            link_up_reg <= 1'b0;
            rx_cnt_reg  <= '0;
            tx_cnt_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            is_hb_reg   <= is_hb_next;
            len_reg     <= len_next;
            count_reg   <= count_next;
            link_up_reg <= link_up_next;
            rx_cnt_reg  <= rx_cnt_next;
            tx_cnt_reg  <= tx_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (rx_item.ready)
        begin
            res_valid_reg <= accept;
        end
    end

    // Payload holds while the result waits
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.out_valid      = res_reg.out_valid;
    assign result.out_byte       = res_reg.out_byte;
    assign result.frame_end      = res_reg.frame_end;
    assign result.heartbeat_seen = res_reg.heartbeat_seen;
    assign result.type_error     = res_reg.type_error;
    assign result.send_heartbeat = res_reg.send_heartbeat;
    assign result.link_dropped   = res_reg.link_dropped;
    assign result.drop_cause     = res_reg.drop_cause;

    // ----------------------------------------------------------- assertions
    // A pending drop result always sees the link down and the parser idle
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.link_dropped |-> !link_up_reg && phase_reg == PH_TYPE)
    else $error("drop result without link down and parser cleared");

    // A heartbeat request restarts the transmit counter
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.send_heartbeat |-> tx_cnt_reg == '0)
    else $error("heartbeat requested but transmit counter not cleared");

    // A received heartbeat restarts the silence counter
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.heartbeat_seen |-> rx_cnt_reg == '0)
    else $error("heartbeat seen but silence counter not cleared");

    // Frame end only ever rides on a data byte, after which the parser waits for type
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.frame_end |-> res_reg.out_valid && phase_reg == PH_TYPE)
    else $error("frame end without payload byte or parser not back at type");

endmodule
